### hw/rtl/b2s_pkg.sv
// ============================================================================
// BLAKE2s engine package
// Shared types, constants and helper functions for the BLAKE2s hash engine.
// ============================================================================
package b2s_pkg;

    localparam int unsigned ROUND_COUNT = 10;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIGEST_LEN = 3'd0;
    localparam logic [2:0] CFG_KEY_LEN    = 3'd1;
    localparam logic [2:0] CFG_KEY_0      = 3'd2;
    localparam logic [2:0] CFG_KEY_1      = 3'd3;
    localparam logic [2:0] CFG_KEY_2      = 3'd4;
    localparam logic [2:0] CFG_KEY_3      = 3'd5;

    // Initialization vector.
    localparam logic [255:0] IV_FLAT = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};
    localparam logic [31:0] PARAM_BASE = 32'h01010000;

    // Front-to-back queue entry: one input word after clamping.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        fin;
    } t_qent;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        iv_word = IV_FLAT[idx*32 +: 32];
    endfunction

    // Message schedule: word index for round r (0 to 9; others give round 0), slot j.
    function automatic logic [3:0] sched(input logic [3:0] r, input logic [3:0] j);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            4'd9: row = 64'h0dc3e9bf5167482a;
            default: row = 64'hfedcba9876543210;
        endcase
        sched = row[j*4 +: 4];
    endfunction

endpackage

### hw/rtl/b2s_front.sv
// ============================================================================
// BLAKE2s front end
// Accepts input words, clamps the byte count and pushes them into a queue.
// ============================================================================
module b2s_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [31:0]   i_data_word,
    input  logic [2:0]    i_byte_count,
    input  logic          i_final_item,
    input  logic          i_pop,
    output logic          o_q_valid,
    output b2s_pkg::t_qent o_q_ent
);
    import b2s_pkg::*;

    t_qent              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic               w_push, w_pop;
    t_qent              w_ent;

    // Clamp the byte count when classifying the word.
    always_comb begin
        w_ent.data  = i_data_word;
        w_ent.count = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        w_ent.fin   = i_final_item;
    end

    assign o_stall   = (r_cnt == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_ent   = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_ent;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !w_push) else $error("push when full");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> o_q_valid) else $error("pop when empty");

endmodule

### hw/rtl/b2s_back.sv
// ============================================================================
// BLAKE2s back end
// Buffers bytes, runs compressions with one G function per cycle, and emits
// the digest words through an output register.
// ============================================================================
module b2s_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b2s_pkg::t_qent i_q_ent,
    output logic           o_pop,
    input  logic [5:0]     i_dlen,
    input  logic [5:0]     i_klen,
    input  logic [255:0]   i_key,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_digest_bytes,
    output logic           o_digest_last
);
    import b2s_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BYTE = 3'd1;
    localparam logic [2:0] ST_INIT = 3'd2;
    localparam logic [2:0] ST_G    = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic        r_open;
    logic [31:0] r_h [8];
    logic [31:0] r_m [16];
    logic [31:0] r_v [16];
    logic [63:0] r_t;
    logic [6:0]  r_fill;
    logic [2:0]  r_bi;
    logic        r_last;
    logic [3:0]  r_round;
    logic [2:0]  r_gi;
    logic [3:0]  r_oi;
    logic [5:0]  r_dl;
    logic        r_ovalid;
    logic [31:0] r_ow;
    logic [2:0]  r_ob;
    logic        r_ol;

    logic [5:0] w_kl, w_dl;
    assign w_kl = (i_klen > 6'd32) ? 6'd32 : i_klen;
    assign w_dl = (i_dlen == 6'd0) ? 6'd1 : ((i_dlen > 6'd32) ? 6'd32 : i_dlen);

    // G function operand selection.
    logic [3:0] w_a, w_b, w_c, w_d;
    logic [3:0] w_rm;
    logic [31:0] w_x, w_y, a1, d1, c1, b1, a2, d2, c2, b2;
    always_comb begin
        case (r_gi)
            3'd0: begin w_a = 4'd0; w_b = 4'd4; w_c = 4'd8;  w_d = 4'd12; end
            3'd1: begin w_a = 4'd1; w_b = 4'd5; w_c = 4'd9;  w_d = 4'd13; end
            3'd2: begin w_a = 4'd2; w_b = 4'd6; w_c = 4'd10; w_d = 4'd14; end
            3'd3: begin w_a = 4'd3; w_b = 4'd7; w_c = 4'd11; w_d = 4'd15; end
            3'd4: begin w_a = 4'd0; w_b = 4'd5; w_c = 4'd10; w_d = 4'd15; end
            3'd5: begin w_a = 4'd1; w_b = 4'd6; w_c = 4'd11; w_d = 4'd12; end
            3'd6: begin w_a = 4'd2; w_b = 4'd7; w_c = 4'd8;  w_d = 4'd13; end
            default: begin w_a = 4'd3; w_b = 4'd4; w_c = 4'd9; w_d = 4'd14; end
        endcase
        w_rm = (r_round >= 4'd10) ? r_round - 4'd10 : r_round;
        w_x = r_m[sched(w_rm, {r_gi, 1'b0})];
        w_y = r_m[sched(w_rm, {r_gi, 1'b1})];
        a1 = r_v[w_a] + r_v[w_b] + w_x;
        d1 = r_v[w_d] ^ a1;  d1 = {d1[15:0], d1[31:16]};
        c1 = r_v[w_c] + d1;
        b1 = r_v[w_b] ^ c1;  b1 = {b1[11:0], b1[31:12]};
        a2 = a1 + b1 + w_y;
        d2 = d1 ^ a2;        d2 = {d2[7:0], d2[31:8]};
        c2 = c1 + d2;
        b2 = b1 ^ c2;        b2 = {b2[6:0], b2[31:7]};
    end

    logic [6:0] w_pos;
    logic       w_need_comp;
    assign w_pos = r_fill;
    assign w_need_comp = (r_fill >= 7'd64);

    // Digest word for the current output index.
    logic [5:0]  w_rem;
    logic [2:0]  w_nb;
    logic [31:0] w_hw;
    always_comb begin
        w_rem = r_dl - {r_oi[2:0], 2'b00};
        w_nb  = (w_rem > 6'd4) ? 3'd4 : w_rem[2:0];
        w_hw  = r_h[r_oi[2:0]];
        case (w_nb)
            3'd1: w_hw = {24'd0, w_hw[7:0]};
            3'd2: w_hw = {16'd0, w_hw[15:0]};
            3'd3: w_hw = {8'd0, w_hw[23:0]};
            default: ;
        endcase
    end

    // A plain word leaves the queue once its bytes are buffered; the final
    // word leaves when its last digest word is loaded.
    logic w_fin_pop;
    assign w_fin_pop = (r_state == ST_OUT) && (!r_ovalid || !i_stall) && (w_rem <= 6'd4);
    assign o_pop = ((r_state == ST_BYTE) && (r_bi >= i_q_ent.count) && !(i_q_ent.fin)) ||
                   w_fin_pop;

    assign o_valid = r_ovalid;
    assign o_digest_word = r_ow;
    assign o_digest_bytes = r_ob;
    assign o_digest_last = r_ol;

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_open   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != ST_OUT)) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (!r_open) begin
                            for (int i = 1; i < 8; i++) r_h[i] <= iv_word(3'(i));
                            r_h[0] <= iv_word(3'd0) ^ PARAM_BASE ^
                                      {18'd0, w_kl, 8'd0} ^ {26'd0, w_dl};
                            r_t <= '0;
                            r_dl <= w_dl;
                            for (int i = 0; i < 32; i++) begin
                                if (6'(i) < w_kl)
                                    r_m[i/4][(i%4)*8 +: 8] <= i_key[i*8 +: 8];
                                else
                                    r_m[i/4][(i%4)*8 +: 8] <= 8'd0;
                            end
                            for (int i = 8; i < 16; i++) r_m[i] <= '0;
                            r_fill <= (w_kl != 6'd0) ? 7'd64 : 7'd0;
                            r_open <= 1'b1;
                        end
                        r_bi <= '0;
                        r_state <= ST_BYTE;
                    end
                end
                ST_BYTE: begin
                    if (r_bi < i_q_ent.count) begin
                        if (w_need_comp) begin
                            r_t <= r_t + 64'd64;
                            r_last <= 1'b0;
                            r_state <= ST_INIT;
                        end else begin
                            r_m[w_pos[5:2]][w_pos[1:0]*8 +: 8] <=
                                i_q_ent.data[r_bi[1:0]*8 +: 8];
                            r_fill <= r_fill + 7'd1;
                            r_bi <= r_bi + 3'd1;
                        end
                    end else if (i_q_ent.fin) begin
                        r_t <= r_t + 64'(r_fill);
                        r_last <= 1'b1;
                        r_state <= ST_INIT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_INIT: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    for (int i = 0; i < 4; i++) r_v[i+8] <= iv_word(3'(i));
                    r_v[12] <= iv_word(3'd4) ^ r_t[31:0];
                    r_v[13] <= iv_word(3'd5) ^ r_t[63:32];
                    r_v[14] <= iv_word(3'd6) ^ {32{r_last}};
                    r_v[15] <= iv_word(3'd7);
                    r_round <= '0;
                    r_gi <= '0;
                    r_state <= ST_G;
                end
                ST_G: begin
                    r_v[w_a] <= a2; r_v[w_b] <= b2; r_v[w_c] <= c2; r_v[w_d] <= d2;
                    r_gi <= r_gi + 3'd1;
                    if (r_gi == 3'd7) begin
                        r_round <= r_round + 4'd1;
                        if (r_round == 4'(ROUND_COUNT - 1)) r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i+8];
                    if (r_last) begin
                        r_oi <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        for (int i = 0; i < 16; i++) r_m[i] <= '0;
                        r_fill <= '0;
                        r_state <= ST_BYTE;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_ow <= w_hw;
                        r_ob <= w_nb;
                        r_ol <= (w_rem <= 6'd4);
                        r_oi <= r_oi + 4'd1;
                        if (w_rem <= 6'd4) begin
                            r_open <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_gi_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G) |-> (r_round < 4'(ROUND_COUNT))) else $error("round overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid) else $error("result dropped");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_fill <= 7'd64)) else $error("fill overrun");

endmodule

### hw/rtl/blake2s_hash_engine_core.sv
// ============================================================================
// BLAKE2s hash engine core
// Keyed BLAKE2s with a word queue in front of a compression sequencer.
// ============================================================================
//  channel  | direction | handshake
//  input    | in        | i_valid / o_stall, word data_word/byte_count/final
//  digest   | out       | o_valid / i_stall, digest_word/bytes/last
//  config   | in        | i_cfg_we, i_cfg_index, i_cfg_data
// For each word the back end leaves the idle state, stores its bytes in turn in
// the byte state and closes the word. A compression runs the init state, the G
// states with one G function per cycle, and the fold state. Digest words leave
// one per cycle through an output register while the receiver does not stall.
// Reset is synchronous, active low; configuration applies at message start.
// The four-entry queue lets the input run ahead while the back end compresses.
// ============================================================================
module blake2s_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_bytes,
    output logic        o_digest_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import b2s_pkg::*;

    logic [5:0]   r_dlen, r_klen;
    logic [255:0] r_key;
    logic         w_qv, w_pop;
    t_qent        w_qe;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen <= 6'd32;
            r_klen <= '0;
            r_key  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIGEST_LEN: r_dlen <= i_cfg_data[5:0];
                CFG_KEY_LEN:    r_klen <= i_cfg_data[5:0];
                CFG_KEY_0:      r_key[63:0]    <= i_cfg_data;
                CFG_KEY_1:      r_key[127:64]  <= i_cfg_data;
                CFG_KEY_2:      r_key[191:128] <= i_cfg_data;
                CFG_KEY_3:      r_key[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    b2s_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_data_word, .i_byte_count, .i_final_item,
        .i_pop(w_pop), .o_q_valid(w_qv), .o_q_ent(w_qe));

    b2s_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_ent(w_qe), .o_pop(w_pop),
        .i_dlen(r_dlen), .i_klen(r_klen), .i_key(r_key),
        .o_valid, .i_stall, .o_digest_word, .o_digest_bytes, .o_digest_last);

endmodule

### bench/blake2s_hash_engine_core_tb.sv
// ----------------------------------------------------------------------------
// BLAKE2s hash engine core testbench
// Feeds message words through the input channel, writes configuration
// between messages, and checks every digest word against a BLAKE2s model
// kept inside the bench, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module blake2s_hash_engine_core_tb;
    import b2s_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int WATCH_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } digest_word_t;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        fin;
        logic        typed;
        logic [31:0] first_word;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_final_item;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_bytes;
    logic        o_digest_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    blake2s_hash_engine_core uut (.*);

    // Model state: configuration and hashing context.
    logic [5:0]  mdl_dlen;
    logic [5:0]  mdl_klen;
    logic [63:0] mdl_key [4];
    logic [31:0] chain [8];
    logic [63:0] total_bytes;
    logic [31:0] msg_block [16];
    int          block_fill;
    logic        msg_active;
    logic [31:0] vec [16];

    digest_word_t pending_digest [$];
    int errors = 0;
    int sender_idle = 0;
    int receiver_stall = 0;

    logic [63:0] perm_rows [10] = '{
        64'hfedcba9876543210, 64'h357b20c16df984ae, 64'h491763eadf250c8b,
        64'h8f04a562ebcd1397, 64'hd386cb1efa427509, 64'h91ef57d438b0a6c2,
        64'hb8293670a4def15c, 64'ha2684f05931ce7bd, 64'h5a417d2c803b9ef6,
        64'h0dc3e9bf5167482a};

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] iv_at(int k);
        return IV_FLAT[k*32 +: 32];
    endfunction

    task automatic quarter(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
        vec[a] = vec[a] + vec[b] + x;
        vec[d] = ror(vec[d] ^ vec[a], 16);
        vec[c] = vec[c] + vec[d];
        vec[b] = ror(vec[b] ^ vec[c], 12);
        vec[a] = vec[a] + vec[b] + y;
        vec[d] = ror(vec[d] ^ vec[a], 8);
        vec[c] = vec[c] + vec[d];
        vec[b] = ror(vec[b] ^ vec[c], 7);
    endtask

    task automatic compress_block(logic last_block);
        logic [63:0] row;
        logic [31:0] m [16];
        for (int k = 0; k < 8; k++) begin
            vec[k] = chain[k];
            vec[k+8] = iv_at(k);
        end
        vec[12] ^= total_bytes[31:0];
        vec[13] ^= total_bytes[63:32];
        if (last_block) vec[14] = ~vec[14];
        for (int r = 0; r < ROUND_COUNT; r++) begin
            row = perm_rows[r % 10];
            for (int j = 0; j < 16; j++) m[j] = msg_block[row[j*4 +: 4]];
            quarter(0, 4, 8, 12, m[0], m[1]);
            quarter(1, 5, 9, 13, m[2], m[3]);
            quarter(2, 6, 10, 14, m[4], m[5]);
            quarter(3, 7, 11, 15, m[6], m[7]);
            quarter(0, 5, 10, 15, m[8], m[9]);
            quarter(1, 6, 11, 12, m[10], m[11]);
            quarter(2, 7, 8, 13, m[12], m[13]);
            quarter(3, 4, 9, 14, m[14], m[15]);
        end
        for (int k = 0; k < 8; k++) chain[k] ^= vec[k] ^ vec[k+8];
    endtask

    function automatic int key_len_eff();
        return (mdl_klen > 32) ? 32 : int'(mdl_klen);
    endfunction

    function automatic int digest_len_eff();
        if (mdl_dlen == 0) return 1;
        return (mdl_dlen > 32) ? 32 : int'(mdl_dlen);
    endfunction

    // Open a message from the current register values.
    task automatic open_message();
        int kl;
        kl = key_len_eff();
        for (int k = 0; k < 8; k++) chain[k] = iv_at(k);
        chain[0] ^= PARAM_BASE ^ (kl << 8) ^ digest_len_eff();
        total_bytes = '0;
        for (int k = 0; k < 16; k++) msg_block[k] = '0;
        for (int k = 0; k < kl; k++)
            msg_block[k/4][(k%4)*8 +: 8] = mdl_key[k/8][(k%8)*8 +: 8];
        block_fill = (kl > 0) ? 64 : 0;
        msg_active = 1'b1;
    endtask

    task automatic append_byte(logic [7:0] b);
        if (block_fill >= 64) begin
            total_bytes += 64;
            compress_block(1'b0);
            for (int k = 0; k < 16; k++) msg_block[k] = '0;
            block_fill = 0;
        end
        msg_block[block_fill/4][(block_fill%4)*8 +: 8] = b;
        block_fill++;
    endtask

    // Absorb one word; on the final word queue the expected digest words.
    task automatic absorb_word(stim_row_t w);
        int n, dl, nw, nb;
        digest_word_t e;
        if (!msg_active) open_message();
        n = (w.cnt > 4) ? 4 : int'(w.cnt);
        for (int k = 0; k < n; k++) append_byte(w.data[k*8 +: 8]);
        if (w.fin) begin
            total_bytes += block_fill;
            compress_block(1'b1);
            dl = digest_len_eff();
            nw = (dl + 3) / 4;
            for (int k = 0; k < nw; k++) begin
                nb = (dl - k*4 > 4) ? 4 : dl - k*4;
                e.word = chain[k];
                if (nb < 4) e.word &= (32'd1 << (nb*8)) - 1;
                if (k == 0 && w.typed) e.word = w.first_word;
                e.nbytes = 3'(nb);
                e.last = (k + 1 == nw);
                pending_digest.push_back(e);
            end
            msg_active = 1'b0;
        end
    endtask

    task automatic send_word(stim_row_t w);
        if ($urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_word <= w.data;
        i_byte_count <= w.cnt;
        i_final_item <= w.fin;
        do @(posedge i_clk); while (o_stall);
        absorb_word(w);
    endtask

    // Lower valid, let every digest word drain and the back end settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_DIGEST_LEN) mdl_dlen = val[5:0];
        else if (idx == CFG_KEY_LEN) mdl_klen = val[5:0];
        else if (idx >= CFG_KEY_0 && idx <= CFG_KEY_3) mdl_key[idx - CFG_KEY_0] = val;
    endtask

    task automatic configure(logic [63:0] dlen, logic [63:0] klen, logic randomize_key);
        write_reg(CFG_DIGEST_LEN, dlen);
        write_reg(CFG_KEY_LEN, klen);
        if (randomize_key) begin
            write_reg(CFG_KEY_0, {$urandom, $urandom});
            write_reg(CFG_KEY_1, {$urandom, $urandom});
            write_reg(CFG_KEY_2, {$urandom, $urandom});
            write_reg(CFG_KEY_3, {$urandom, $urandom});
        end
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Digest channel: random stall and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        digest_word_t e;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < receiver_stall);
            if (o_valid && !i_stall) begin
                if (pending_digest.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected digest word %h", o_digest_word);
                end else begin
                    e = pending_digest.pop_front();
                    if (o_digest_word !== e.word || o_digest_bytes !== e.nbytes ||
                        o_digest_last !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.nbytes, e.last, o_digest_word,
                                     o_digest_bytes, o_digest_last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted input word, accepted digest word or register write.
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCH_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        stim_row_t directed [$];
        stim_row_t w;
        int items, group, nwords;
        logic [63:0] dl_pick, kl_pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data_word = '0;
        i_byte_count = '0;
        i_final_item = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mdl_dlen = 6'd32;
        mdl_klen = 6'd0;
        for (int k = 0; k < 4; k++) mdl_key[k] = '0;
        msg_active = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message and "abc" have well-known unkeyed digests.
        directed.push_back('{32'h0, 3'd0, 1'b1, 1'b1, 32'h307a2169});
        directed.push_back('{32'h00636261, 3'd3, 1'b1, 1'b1, 32'h8c5e8c50});
        // Byte count above four, short words mid-message, zero-byte final.
        directed.push_back('{32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, 32'h0});
        directed.push_back('{32'h0, 3'd7, 1'b1, 1'b0, 32'h0});
        directed.push_back('{32'h12345678, 3'd2, 1'b0, 1'b0, 32'h0});
        directed.push_back('{32'hA5A5A5A5, 3'd1, 1'b0, 1'b0, 32'h0});
        directed.push_back('{32'hDEADBEEF, 3'd0, 1'b1, 1'b0, 32'h0});
        // Exactly one full block: compressed only once, with the last flag.
        for (int k = 0; k < 16; k++)
            directed.push_back('{$urandom, 3'd4, k == 15, 1'b0, 32'h0});
        foreach (directed[k]) send_word(directed[k]);
        drain();

        // Random messages, reconfigured every few messages.
        items = 0;
        group = 0;
        while (items < 160) begin
            if (group % 3 == 0) begin
                case ((group / 3) % 5)
                    0: begin dl_pick = 1;  kl_pick = 32; end
                    1: begin dl_pick = 0;  kl_pick = 63; end
                    2: begin dl_pick = 63; kl_pick = 0;  end
                    3: begin dl_pick = 32; kl_pick = 1;  end
                    default: begin
                        dl_pick = $urandom_range(63);
                        kl_pick = $urandom_range(63);
                    end
                endcase
                configure(dl_pick, kl_pick, 1'b1);
            end
            case (group % 4)
                0: begin sender_idle = 0;  receiver_stall = 0;  end
                1: begin sender_idle = 48; receiver_stall = 0;  end
                2: begin sender_idle = 0;  receiver_stall = 48; end
                default: begin sender_idle = 38; receiver_stall = 38; end
            endcase
            nwords = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
            for (int k = 0; k <= nwords; k++) begin
                w.data = $urandom;
                w.fin = (k == nwords);
                if (w.fin || $urandom_range(9) == 0) w.cnt = $urandom_range(7);
                else w.cnt = 3'd4;
                w.typed = 1'b0;
                w.first_word = '0;
                send_word(w);
                items++;
            end
            group++;
            if (group % 3 == 0) drain();
        end
        drain();

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
